### rtl/rme_pkg.sv
// Shared types, constants and tables for the rotation matrix to Euler angles block.
package rme_pkg;

   // Default sizes
   localparam int COEFF_WIDTH_DEF   = 18;
   localparam int ANGLE_WIDTH_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 18;

   // Fixed internal widths
   localparam int CONV_W     = 4;
   localparam int ZW         = 34;  // angle accumulator, Q30 radians
   localparam int SQRT_N_W   = 64;  // radicand
   localparam int SQRT_Q_W   = 32;  // root
   localparam int SQRT_R_W   = 34;  // partial remainder
   localparam int SQRT_STEPS = SQRT_N_W / 2;
   localparam int PIV_W      = 17;  // pivot magnitude below 1.0
   localparam int SQ_W       = 2 * PIV_W;
   localparam int DEG_W      = 30;
   localparam int RAD_W      = ZW - 13;
   localparam int ENC_W      = 25;

   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [DEG_W-1:0]     DEG_SCALE   = 30'd961263669;
   localparam logic [SQ_W-1:0]      ONE_SQ      = 34'h1_0000_0000;

   // Convention codes
   localparam logic [CONV_W-1:0] CONV_XYZ = 4'd0;
   localparam logic [CONV_W-1:0] CONV_XZY = 4'd1;
   localparam logic [CONV_W-1:0] CONV_YXZ = 4'd2;
   localparam logic [CONV_W-1:0] CONV_YZX = 4'd3;
   localparam logic [CONV_W-1:0] CONV_ZXY = 4'd4;
   localparam logic [CONV_W-1:0] CONV_ZYX = 4'd5;
   localparam logic [CONV_W-1:0] CONV_XYX = 4'd6;
   localparam logic [CONV_W-1:0] CONV_XZX = 4'd7;
   localparam logic [CONV_W-1:0] CONV_YXY = 4'd8;
   localparam logic [CONV_W-1:0] CONV_YZY = 4'd9;
   localparam logic [CONV_W-1:0] CONV_ZXZ = 4'd10;
   localparam logic [CONV_W-1:0] CONV_ZYZ = 4'd11;

   // Middle angle function
   typedef enum logic [1:0] {
      KIND_ASIN,
      KIND_ASIN_NEG,
      KIND_ACOS
   } kind_type;

   // atan2 argument special cases
   typedef enum logic [1:0] {
      SP_NONE,
      SP_ZERO,
      SP_PI
   } special_type;

   // Matrix operand: +-(index+1), index row-major 0..8
   typedef logic signed [4:0] code_type;

   typedef struct packed {
      code_type piv;
      kind_type kind;
      code_type a1_y;
      code_type a1_x;
      code_type a3_y;
      code_type a3_x;
      code_type lk_y;
      code_type lk_x;
   } conv_type;

   typedef struct packed {
      logic     bad;
      logic     lock_pos;
      logic     lock_neg;
      kind_type kind;
   } flags_type;

   function automatic logic conv_is_valid(input logic [CONV_W-1:0] c);
      return c <= CONV_ZYZ;
   endfunction

   // Per-convention pivot, middle angle kind and atan2 operand pairs
   function automatic conv_type conv_entry(input logic [CONV_W-1:0] c);
      conv_type e;
      unique case (c)
         CONV_XYZ: e = '{ 5'sd3, KIND_ASIN,     -5'sd6,  5'sd9, -5'sd2,  5'sd1,  5'sd4,  5'sd5};
         CONV_XZY: e = '{ 5'sd2, KIND_ASIN_NEG,  5'sd8,  5'sd5,  5'sd3,  5'sd1, -5'sd7,  5'sd9};
         CONV_YXZ: e = '{ 5'sd6, KIND_ASIN_NEG,  5'sd3,  5'sd9,  5'sd4,  5'sd5, -5'sd2,  5'sd1};
         CONV_YZX: e = '{ 5'sd4, KIND_ASIN,     -5'sd7,  5'sd1, -5'sd6,  5'sd5,  5'sd8,  5'sd9};
         CONV_ZXY: e = '{ 5'sd8, KIND_ASIN,     -5'sd2,  5'sd5, -5'sd7,  5'sd9,  5'sd3,  5'sd1};
         CONV_ZYX: e = '{ 5'sd7, KIND_ASIN_NEG,  5'sd4,  5'sd1,  5'sd8,  5'sd9, -5'sd6,  5'sd5};
         CONV_XYX: e = '{ 5'sd1, KIND_ACOS,      5'sd4, -5'sd7,  5'sd2,  5'sd3, -5'sd6,  5'sd5};
         CONV_XZX: e = '{ 5'sd1, KIND_ACOS,      5'sd7,  5'sd4,  5'sd3, -5'sd2,  5'sd8,  5'sd9};
         CONV_YXY: e = '{ 5'sd5, KIND_ACOS,      5'sd2,  5'sd8,  5'sd4, -5'sd6,  5'sd3,  5'sd1};
         CONV_YZY: e = '{ 5'sd5, KIND_ACOS,      5'sd8, -5'sd2,  5'sd6,  5'sd4, -5'sd7,  5'sd9};
         CONV_ZXZ: e = '{ 5'sd9, KIND_ACOS,      5'sd3, -5'sd6,  5'sd7,  5'sd8, -5'sd2,  5'sd1};
         CONV_ZYZ: e = '{ 5'sd9, KIND_ACOS,      5'sd6,  5'sd3,  5'sd8, -5'sd7,  5'sd4,  5'sd5};
         default:  e = '{ 5'sd1, KIND_ACOS,      5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1};
      endcase
      return e;
   endfunction

   // atan(2^-i) in Q30
   function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
      logic signed [ZW-1:0] t;
      case (i)
         0:  t = 34'sh3243F6A8;
         1:  t = 34'sh1DAC6705;
         2:  t = 34'sh0FADBAFC;
         3:  t = 34'sh07F56EA6;
         4:  t = 34'sh03FEAB76;
         5:  t = 34'sh01FFD55B;
         6:  t = 34'sh00FFFAAA;
         7:  t = 34'sh007FFF55;
         8:  t = 34'sh003FFFEA;
         9:  t = 34'sh001FFFFD;
         10: t = 34'sh000FFFFF;
         11: t = 34'sh0007FFFF;
         12: t = 34'sh0003FFFF;
         13: t = 34'sh0001FFFF;
         14: t = 34'sh0000FFFF;
         15: t = 34'sh00007FFF;
         16: t = 34'sh00003FFF;
         17: t = 34'sh00001FFF;
         18: t = 34'sh00000FFF;
         19: t = 34'sh000007FF;
         20: t = 34'sh000003FF;
         21: t = 34'sh000001FF;
         22: t = 34'sh000000FF;
         23: t = 34'sh0000007F;
         24: t = 34'sh0000003F;
         25: t = 34'sh0000001F;
         26: t = 34'sh0000000F;
         27: t = 34'sh00000008;
         28: t = 34'sh00000004;
         29: t = 34'sh00000002;
         30: t = 34'sh00000001;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

### rtl/rme_sqrt_stage.sv
// One digit of the pipelined integer square root (two radicand bits per stage).
module rme_sqrt_stage (
   input  logic                          clock,
   input  logic                          en,
   input  logic [rme_pkg::SQRT_R_W-1:0]  rem_prev,
   input  logic [rme_pkg::SQRT_Q_W-1:0]  root_prev,
   input  logic [rme_pkg::SQRT_N_W-1:0]  rad_prev,
   output logic [rme_pkg::SQRT_R_W-1:0]  rem_ff,
   output logic [rme_pkg::SQRT_Q_W-1:0]  root_ff,
   output logic [rme_pkg::SQRT_N_W-1:0]  rad_ff
);
   import rme_pkg::*;

   logic [SQRT_R_W+1:0] acc;
   logic [SQRT_R_W+1:0] trial;
   logic [SQRT_R_W-1:0] rem_in;
   logic [SQRT_Q_W-1:0] root_in;

   // Bring down the next bit pair and try root*4+1
   assign acc   = {rem_prev, rad_prev[SQRT_N_W-1 -: 2]};
   assign trial = {{(SQRT_R_W-SQRT_Q_W){1'b0}}, root_prev, 2'b01};

   always_comb begin
      if (acc >= trial) begin
         rem_in  = SQRT_R_W'(acc - trial);
         root_in = {root_prev[SQRT_Q_W-2:0], 1'b1};
      end else begin
         rem_in  = SQRT_R_W'(acc);
         root_in = {root_prev[SQRT_Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= {rad_prev[SQRT_N_W-3:0], 2'b00};
      end
   end

endmodule

### rtl/rme_prerot.sv
// CORDIC entry: special argument detection, scaling and quadrant pre-rotation.
module rme_prerot #(
   parameter int IN_W = 33,
   parameter int CW   = IN_W + 27
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [IN_W-1:0]         y_arg,
   input  logic signed [IN_W-1:0]         x_arg,
   output logic signed [CW-1:0]           x_ff,
   output logic signed [CW-1:0]           y_ff,
   output logic signed [rme_pkg::ZW-1:0]  z_ff,
   output rme_pkg::special_type           sp_ff
);
   import rme_pkg::*;

   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [ZW-1:0] z_in;
   special_type          sp_in;

   // Scale by 2^24 with headroom for CORDIC growth
   assign xs = $signed({{(CW-IN_W-24){x_arg[IN_W-1]}}, x_arg, 24'd0});
   assign ys = $signed({{(CW-IN_W-24){y_arg[IN_W-1]}}, y_arg, 24'd0});

   always_comb begin
      if (x_arg == '0 && y_arg == '0) begin
         sp_in = SP_ZERO;
      end else if (y_arg == '0 && x_arg < 0) begin
         sp_in = SP_PI;
      end else begin
         sp_in = SP_NONE;
      end
      // Rotate left half plane by -+90 degrees
      if (xs < 0) begin
         if (ys >= 0) begin
            x_in = ys;
            y_in = -xs;
            z_in = HALF_PI_Q30;
         end else begin
            x_in = -ys;
            y_in = xs;
            z_in = -HALF_PI_Q30;
         end
      end else begin
         x_in = xs;
         y_in = ys;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         sp_ff <= sp_in;
      end
   end

endmodule

### rtl/rme_cordic_stage.sv
// One vectoring CORDIC micro-rotation with its output register.
module rme_cordic_stage #(
   parameter int CW    = 60,
   parameter int SHIFT = 0
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [CW-1:0]           x_prev,
   input  logic signed [CW-1:0]           y_prev,
   input  logic signed [rme_pkg::ZW-1:0]  z_prev,
   output logic signed [CW-1:0]           x_ff,
   output logic signed [CW-1:0]           y_ff,
   output logic signed [rme_pkg::ZW-1:0]  z_ff
);
   import rme_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE = atan_q30(SHIFT);

   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;

   // Floor shifts of the old vector
   assign xs = x_prev >>> SHIFT;
   assign ys = y_prev >>> SHIFT;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!y_prev[CW-1]) begin
            x_ff <= x_prev + ys;
            y_ff <= y_prev - xs;
            z_ff <= z_prev + ANGLE;
         end else begin
            x_ff <= x_prev - ys;
            y_ff <= y_prev + xs;
            z_ff <= z_prev - ANGLE;
         end
      end
   end

endmodule

### rtl/rme_encode.sv
// Two-stage angle encoder: Q30 radians to output radians or degrees, saturated.
module rme_encode #(
   parameter int ANGLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic                           deg_mode,
   input  logic signed [rme_pkg::ZW-1:0]  angle_z,
   output logic signed [ANGLE_WIDTH-1:0]  angle_ff
);
   import rme_pkg::*;

   localparam int LOW_W = 17;
   localparam int HI_W  = ZW - LOW_W;
   localparam int EW    = ((ANGLE_WIDTH > ENC_W) ? ANGLE_WIDTH : ENC_W) + 1;

   logic signed [ZW:0]                zr;
   logic signed [RAD_W-1:0]           rad_in;
   logic signed [RAD_W-1:0]           rad_ff;
   logic signed [HI_W+DEG_W:0]        ph_in;
   logic signed [HI_W+DEG_W:0]        ph_ff;
   logic [LOW_W+DEG_W-1:0]            pl_in;
   logic [LOW_W+DEG_W-1:0]            pl_ff;
   logic                              deg_mode_ff;
   logic signed [63:0]                dsum;
   logic signed [ENC_W-1:0]           val;
   logic signed [EW-1:0]              ext;
   logic signed [EW-1:0]              lim_hi;
   logic signed [EW-1:0]              lim_lo;
   logic signed [ANGLE_WIDTH-1:0]     angle_in;

   // Stage A: radian rounding and degree partial products
   assign zr     = $signed({angle_z[ZW-1], angle_z}) + (ZW+1)'(8192);
   assign rad_in = zr[ZW -: RAD_W];
   assign ph_in  = $signed(angle_z[ZW-1:LOW_W]) * $signed({1'b0, DEG_SCALE});
   assign pl_in  = angle_z[LOW_W-1:0] * DEG_SCALE;

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff      <= rad_in;
         ph_ff       <= ph_in;
         pl_ff       <= pl_in;
         deg_mode_ff <= deg_mode;
      end
   end

   // Stage B: combine, round and saturate
   assign dsum = (64'(ph_ff) <<< LOW_W) + $signed(64'(pl_ff)) + (64'sd1 <<< 38);
   assign val  = deg_mode_ff ? dsum[63 -: ENC_W]
                             : $signed({{(ENC_W-RAD_W){rad_ff[RAD_W-1]}}, rad_ff});
   assign ext    = $signed({{(EW-ENC_W){val[ENC_W-1]}}, val});
   assign lim_hi = $signed({{(EW-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}});
   assign lim_lo = ~lim_hi;

   always_comb begin
      if (ext > lim_hi) begin
         angle_in = lim_hi[ANGLE_WIDTH-1:0];
      end else if (ext < lim_lo) begin
         angle_in = lim_lo[ANGLE_WIDTH-1:0];
      end else begin
         angle_in = ext[ANGLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

endmodule

### rtl/rotation_matrix_to_euler_angles_core.sv
// Rotation matrix to Euler angles for all twelve axis orders, fully pipelined.
//
// Use: an item is a 3x3 rotation matrix (16 fraction bits) plus a convention
// code; it is taken on req_ when req_valid is high and req_stall is low. Each
// item yields one result on rsp_: three angles and bad_convention, taken when
// rsp_valid is high and rsp_stall is low. csr_ writes the degree/radian bit
// and is always ready; write it only while no item is in flight.
// Throughput: one item per cycle while req_stall is low. Depth comes from the
// 32-stage square root for the middle angle, the CORDIC_STAGES vectoring
// stages (three lanes in parallel) and the encoder.
// Stall: a result held on rsp_ does not stop the pipeline; the next finished
// item parks in a skid register, and only when that is full does req_stall
// rise and the whole pipeline freeze in place.
// Reset: all valid bits clear, the angle unit goes to radians; no item is
// lost or repeated across stalls.
module rotation_matrix_to_euler_angles_core #(
   parameter int COEFF_WIDTH   = rme_pkg::COEFF_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = rme_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rme_pkg::CONV_W-1:0]       req_convention,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_00,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_01,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_02,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_10,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_11,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_12,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_20,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_21,
   input  logic signed [COEFF_WIDTH-1:0]    req_coeff_22,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0]    rsp_first_angle,
   output logic signed [ANGLE_WIDTH-1:0]    rsp_second_angle,
   output logic signed [ANGLE_WIDTH-1:0]    rsp_third_angle,
   output logic                             rsp_bad_convention,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_output_in_degrees
);
   import rme_pkg::*;

   localparam int IN_W = ((COEFF_WIDTH + 1) > 33) ? (COEFF_WIDTH + 1) : 33;
   localparam int CW   = IN_W + 27;
   localparam int MW   = 9 * COEFF_WIDTH;
   localparam int LANES = 3;

   typedef struct packed {
      flags_type               f;
      logic signed [IN_W-1:0]  l1y;
      logic signed [IN_W-1:0]  l1x;
      logic signed [IN_W-1:0]  l3y;
      logic signed [IN_W-1:0]  l3x;
      logic signed [PIV_W-1:0] v;
   } front_type;

   typedef struct packed {
      flags_type   f;
      special_type sp1;
      special_type sp2;
      special_type sp3;
   } cordic_sb_type;

   typedef struct packed {
      logic                           bad;
      logic signed [ANGLE_WIDTH-1:0]  a1;
      logic signed [ANGLE_WIDTH-1:0]  a2;
      logic signed [ANGLE_WIDTH-1:0]  a3;
   } result_type;

   // Operand +-m[k] picked from the packed matrix
   function automatic logic signed [IN_W-1:0] pick(input logic [MW-1:0] m,
                                                    input code_type c);
      logic signed [4:0]      mag;
      logic [3:0]             idx;
      logic signed [IN_W-1:0] val;
      mag = c[4] ? -c : c;
      idx = 4'(mag - 5'sd1);
      val = IN_W'($signed(m[idx*COEFF_WIDTH +: COEFF_WIDTH]));
      return c[4] ? -val : val;
   endfunction

   logic en;
   logic skid_valid_ff;

   // ---------------- Stage 0: input register ----------------
   logic               s0_valid_ff;
   logic [CONV_W-1:0]  s0_conv_ff;
   logic [MW-1:0]      s0_m_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_conv_ff <= req_convention;
         s0_m_ff    <= {req_coeff_22, req_coeff_21, req_coeff_20,
                        req_coeff_12, req_coeff_11, req_coeff_10,
                        req_coeff_02, req_coeff_01, req_coeff_00};
      end
   end

   // ---------------- Stage 1: decode and operand select ----------------
   conv_type               cd;
   logic signed [IN_W-1:0] piv;
   logic signed [IN_W-1:0] vfull;
   logic                   lock_any;
   front_type              s1_in;
   front_type              s1_ff;
   logic                   s1_valid_ff;

   assign cd       = conv_entry(s0_conv_ff);
   assign piv      = pick(s0_m_ff, cd.piv);
   assign vfull    = (cd.kind == KIND_ASIN_NEG) ? -piv : piv;
   assign lock_any = (piv >= $signed(IN_W'(65536))) || (piv <= -$signed(IN_W'(65536)));

   always_comb begin
      s1_in.f.bad      = !conv_is_valid(s0_conv_ff);
      s1_in.f.lock_pos = piv >= $signed(IN_W'(65536));
      s1_in.f.lock_neg = piv <= -$signed(IN_W'(65536));
      s1_in.f.kind     = cd.kind;
      s1_in.l1y        = lock_any ? pick(s0_m_ff, cd.lk_y) : pick(s0_m_ff, cd.a1_y);
      s1_in.l1x        = lock_any ? pick(s0_m_ff, cd.lk_x) : pick(s0_m_ff, cd.a1_x);
      s1_in.l3y        = pick(s0_m_ff, cd.a3_y);
      s1_in.l3x        = pick(s0_m_ff, cd.a3_x);
      s1_in.v          = vfull[PIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- Stage 2: pivot square ----------------
   logic signed [SQ_W-1:0] sq_in;
   logic [SQ_W-1:0]        sq_ff;
   front_type              s2_ff;
   logic                   s2_valid_ff;

   assign sq_in = s1_ff.v * s1_ff.v;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s1_ff;
         sq_ff <= sq_in;
      end
   end

   // ---------------- Square root pipeline: r = isqrt((1 - v^2) << 30) ----------------
   logic [SQ_W-1:0]     dif;
   logic [SQRT_R_W-1:0] rem_a  [SQRT_STEPS+1];
   logic [SQRT_Q_W-1:0] root_a [SQRT_STEPS+1];
   logic [SQRT_N_W-1:0] rad_a  [SQRT_STEPS+1];
   front_type           sb_a   [SQRT_STEPS+1];
   logic                sv_a   [SQRT_STEPS+1];

   assign dif       = ONE_SQ - sq_ff;
   assign rem_a[0]  = '0;
   assign root_a[0] = '0;
   assign rad_a[0]  = {dif, {(SQRT_N_W-SQ_W){1'b0}}};
   assign sb_a[0]   = s2_ff;
   assign sv_a[0]   = s2_valid_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      rme_sqrt_stage u_stage (
         .clock     (clock),
         .en        (en),
         .rem_prev  (rem_a[k]),
         .root_prev (root_a[k]),
         .rad_prev  (rad_a[k]),
         .rem_ff    (rem_a[k+1]),
         .root_ff   (root_a[k+1]),
         .rad_ff    (rad_a[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_a[k+1] <= 1'b0;
         end else if (en) begin
            sv_a[k+1] <= sv_a[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_a[k+1] <= sb_a[k];
         end
      end
   end

   // ---------------- CORDIC entry for the three lanes ----------------
   front_type              sq_end;
   logic signed [IN_W-1:0] r_ext;
   logic signed [IN_W-1:0] vs_ext;
   logic signed [IN_W-1:0] ly [LANES];
   logic signed [IN_W-1:0] lx [LANES];
   logic signed [CW-1:0]   cx [LANES][CORDIC_STAGES+1];
   logic signed [CW-1:0]   cy [LANES][CORDIC_STAGES+1];
   logic signed [ZW-1:0]   cz [LANES][CORDIC_STAGES+1];
   special_type            sp [LANES];
   logic                   pre_valid_ff;
   flags_type              pre_flags_ff;

   assign sq_end = sb_a[SQRT_STEPS];
   assign r_ext  = $signed({{(IN_W-SQRT_Q_W){1'b0}}, root_a[SQRT_STEPS]});
   assign vs_ext = $signed({{(IN_W-PIV_W-15){sq_end.v[PIV_W-1]}}, sq_end.v, 15'd0});

   assign ly[0] = sq_end.l1y;
   assign lx[0] = sq_end.l1x;
   assign ly[1] = (sq_end.f.kind == KIND_ACOS) ? r_ext : vs_ext;
   assign lx[1] = (sq_end.f.kind == KIND_ACOS) ? vs_ext : r_ext;
   assign ly[2] = sq_end.l3y;
   assign lx[2] = sq_end.l3x;

   for (genvar l = 0; l < LANES; l++) begin : g_pre
      rme_prerot #(.IN_W(IN_W), .CW(CW)) u_pre (
         .clock (clock),
         .en    (en),
         .y_arg (ly[l]),
         .x_arg (lx[l]),
         .x_ff  (cx[l][0]),
         .y_ff  (cy[l][0]),
         .z_ff  (cz[l][0]),
         .sp_ff (sp[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= sv_a[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_flags_ff <= sq_end.f;
      end
   end

   // ---------------- CORDIC rotations ----------------
   cordic_sb_type csb_a [CORDIC_STAGES+1];
   logic          cv_a  [CORDIC_STAGES+1];

   assign csb_a[0] = '{f: pre_flags_ff, sp1: sp[0], sp2: sp[1], sp3: sp[2]};
   assign cv_a[0]  = pre_valid_ff;

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         rme_cordic_stage #(.CW(CW), .SHIFT(s)) u_rot (
            .clock  (clock),
            .en     (en),
            .x_prev (cx[l][s]),
            .y_prev (cy[l][s]),
            .z_prev (cz[l][s]),
            .x_ff   (cx[l][s+1]),
            .y_ff   (cy[l][s+1]),
            .z_ff   (cz[l][s+1])
         );
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_a[s+1] <= 1'b0;
         end else if (en) begin
            cv_a[s+1] <= cv_a[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            csb_a[s+1] <= csb_a[s];
         end
      end
   end

   // ---------------- Combine: special arguments and gimbal lock ----------------
   cordic_sb_type        cend;
   logic signed [ZW-1:0] z1f;
   logic signed [ZW-1:0] z2f;
   logic signed [ZW-1:0] z3f;
   logic signed [ZW-1:0] a1_in;
   logic signed [ZW-1:0] a2_in;
   logic signed [ZW-1:0] a3_in;
   logic signed [ZW-1:0] a_ff [LANES];
   logic                 cb_valid_ff;
   logic                 cb_bad_ff;

   assign cend = csb_a[CORDIC_STAGES];

   function automatic logic signed [ZW-1:0] fix_z(input special_type s,
                                                  input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] r;
      case (s)
         SP_ZERO: r = '0;
         SP_PI:   r = PI_Q30;
         default: r = z;
      endcase
      return r;
   endfunction

   assign z1f = fix_z(cend.sp1, cz[0][CORDIC_STAGES]);
   assign z2f = fix_z(cend.sp2, cz[1][CORDIC_STAGES]);
   assign z3f = fix_z(cend.sp3, cz[2][CORDIC_STAGES]);

   always_comb begin
      a1_in = z1f;
      a2_in = z2f;
      a3_in = z3f;
      if (cend.f.bad) begin
         a1_in = '0;
         a2_in = '0;
         a3_in = '0;
      end else if (cend.f.lock_pos) begin
         a3_in = '0;
         case (cend.f.kind)
            KIND_ASIN:     a2_in = HALF_PI_Q30;
            KIND_ASIN_NEG: a2_in = -HALF_PI_Q30;
            default:       a2_in = '0;
         endcase
      end else if (cend.f.lock_neg) begin
         a1_in = -z1f;
         a3_in = '0;
         case (cend.f.kind)
            KIND_ASIN:     a2_in = -HALF_PI_Q30;
            KIND_ASIN_NEG: a2_in = HALF_PI_Q30;
            default:       a2_in = PI_Q30;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_valid_ff <= 1'b0;
      end else if (en) begin
         cb_valid_ff <= cv_a[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]   <= a1_in;
         a_ff[1]   <= a2_in;
         a_ff[2]   <= a3_in;
         cb_bad_ff <= cend.f.bad;
      end
   end

   // ---------------- Encoders (two stages) ----------------
   logic                          deg_ff;
   logic signed [ANGLE_WIDTH-1:0] enc [LANES];
   logic                          e1_valid_ff;
   logic                          e2_valid_ff;
   logic                          e1_bad_ff;
   logic                          e2_bad_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_enc
      rme_encode #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_enc (
         .clock    (clock),
         .en       (en),
         .deg_mode (deg_ff),
         .angle_z  (a_ff[l]),
         .angle_ff (enc[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff <= cb_valid_ff;
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_bad_ff <= cb_bad_ff;
         e2_bad_ff <= e1_bad_ff;
      end
   end

   // ---------------- Output register and skid ----------------
   result_type last_item;
   result_type rsp_ff;
   result_type skid_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       skid_valid_in;
   logic       rsp_free;
   logic       load_last;
   logic       load_skid;
   logic       park;

   assign last_item = '{bad: e2_bad_ff, a1: enc[0], a2: enc[1], a3: enc[2]};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign load_last = en && e2_valid_ff && rsp_free;
   assign park      = en && e2_valid_ff && !rsp_free;
   assign load_skid = skid_valid_ff && rsp_free;

   always_comb begin
      if (load_last || load_skid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (park) begin
         skid_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b0;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_skid) begin
         rsp_ff <= skid_ff;
      end else if (load_last) begin
         rsp_ff <= last_item;
      end
      if (park) begin
         skid_ff <= last_item;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_angle    = rsp_ff.a1;
   assign rsp_second_angle   = rsp_ff.a2;
   assign rsp_third_angle    = rsp_ff.a3;
   assign rsp_bad_convention = rsp_ff.bad;

   // ---------------- Unit register ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= 1'b0;
      end else if (csr_valid) begin
         deg_ff <= csr_output_in_degrees;
      end
   end

endmodule

### rtl/rme_checker.sv
// Port-level checks for the rotation matrix to Euler angles block, bound to the top.
module rme_checker #(
   parameter int ANGLE_WIDTH = rme_pkg::ANGLE_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [ANGLE_WIDTH-1:0] rsp_first_angle,
   input logic signed [ANGLE_WIDTH-1:0] rsp_second_angle,
   input logic signed [ANGLE_WIDTH-1:0] rsp_third_angle,
   input logic                          rsp_bad_convention
);

   // Reset empties the result side and opens the input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall active after reset");

   // Input back-pressure only follows a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // An unknown axis order gives zero angles
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_convention) |->
         (rsp_first_angle == '0 && rsp_second_angle == '0 && rsp_third_angle == '0))
      else $error("bad convention with nonzero angles");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_first_angle) && $stable(rsp_second_angle) &&
          $stable(rsp_third_angle) && $stable(rsp_bad_convention)))
      else $error("stalled result changed");

endmodule

bind rotation_matrix_to_euler_angles_core rme_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_rme_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_first_angle    (rsp_first_angle),
   .rsp_second_angle   (rsp_second_angle),
   .rsp_third_angle    (rsp_third_angle),
   .rsp_bad_convention (rsp_bad_convention)
);

### tb/sv/tb_top.sv
// Testbench for the rotation matrix to Euler angles core: random matrices checked against a local predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rme_pkg::*;

   localparam int CW = 18;
   localparam int AW = 24;
   localparam int STAGES = 18;
   localparam int LATENCY = STAGES + 39;
   localparam int IDLE_LIMIT = 4000;
   localparam longint ONE = 65536;
   localparam longint PI_RAD = 64'sd3373259426;
   localparam longint HALF_PI = 64'sd1686629713;
   localparam longint DEG_K = 64'sd961263669;
   localparam logic signed [CW-1:0] COEFF_MIN = -18'sd131071 - 18'sd1;

   typedef struct {
      logic [3:0] conv;
      logic signed [CW-1:0] m [9];
   } matrix_item;

   typedef struct {
      logic signed [AW-1:0] a1, a2, a3;
      logic bad;
   } angle_set;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0, csr_degrees = 0;
   logic req_stall, rsp_valid, csr_ready, rsp_bad_convention;
   logic [3:0] req_convention = '0;
   logic signed [CW-1:0] cf [9] = '{default: '0};
   logic signed [AW-1:0] rsp_first_angle, rsp_second_angle, rsp_third_angle;

   matrix_item pending_q [$];
   angle_set angles_q [$];
   int errors = 0;
   int idle_cycles = 0;
   bit degrees_mode = 0;
   bit stimulus_done = 0;
   int burst_left = 0, gap_left = 0;
   int stall_phase = 0;

   rotation_matrix_to_euler_angles_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_convention(req_convention),
      .req_coeff_00(cf[0]), .req_coeff_01(cf[1]), .req_coeff_02(cf[2]),
      .req_coeff_10(cf[3]), .req_coeff_11(cf[4]), .req_coeff_12(cf[5]),
      .req_coeff_20(cf[6]), .req_coeff_21(cf[7]), .req_coeff_22(cf[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_first_angle(rsp_first_angle), .rsp_second_angle(rsp_second_angle),
      .rsp_third_angle(rsp_third_angle), .rsp_bad_convention(rsp_bad_convention),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_output_in_degrees(csr_degrees));

   initial forever #1 clock = ~clock;

   // floor division by 2^s
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // vectoring CORDIC atan2, Q30 radians
   function automatic longint vec_atan2(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (y == 0 && x < 0) return PI_RAD;
      x = x * (64'sd1 << 24);
      y = y * (64'sd1 << 24);
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_q30(i));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_q30(i));
         end
      end
      return z;
   endfunction

   function automatic longint pick(longint m [9], code_type c);
      if (c > 0) return m[c - 1];
      return -m[-c - 1];
   endfunction

   function automatic logic signed [AW-1:0] to_output(longint z);
      longint v, lim;
      lim = 64'sd1 << (AW - 1);
      if (degrees_mode) v = fshift(z * DEG_K + (64'sd1 << 38), 39);
      else v = fshift(z + (64'sd1 << 13), 14);
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v[AW-1:0];
   endfunction

   function automatic angle_set euler_angles(matrix_item it);
      angle_set o;
      conv_type d;
      longint m [9];
      longint a1, a2, a3, piv, v, r;
      a3 = 0;
      if (!conv_is_valid(it.conv)) begin
         o.a1 = '0; o.a2 = '0; o.a3 = '0; o.bad = 1;
         return o;
      end
      for (int i = 0; i < 9; i++) m[i] = it.m[i];
      d = conv_entry(it.conv);
      piv = m[d.piv - 1];
      if (piv >= ONE) begin
         a1 = vec_atan2(pick(m, d.lk_y), pick(m, d.lk_x));
         a2 = (d.kind == KIND_ACOS) ? 0 : (d.kind == KIND_ASIN ? HALF_PI : -HALF_PI);
      end else if (piv <= -ONE) begin
         a1 = -vec_atan2(pick(m, d.lk_y), pick(m, d.lk_x));
         a2 = (d.kind == KIND_ACOS) ? PI_RAD : (d.kind == KIND_ASIN ? -HALF_PI : HALF_PI);
      end else begin
         v = (d.kind == KIND_ASIN_NEG) ? -piv : piv;
         r = int_sqrt(longint'(((64'sd1 << 32) - v * v)) << 30);
         a1 = vec_atan2(pick(m, d.a1_y), pick(m, d.a1_x));
         a2 = (d.kind == KIND_ACOS) ? vec_atan2(r, v * 32768) : vec_atan2(v * 32768, r);
         a3 = vec_atan2(pick(m, d.a3_y), pick(m, d.a3_x));
      end
      o.a1 = to_output(a1); o.a2 = to_output(a2); o.a3 = to_output(a3); o.bad = 0;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic logic signed [CW-1:0] rand_coeff();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
         1: return $urandom_range(0, 1) ? 18'sd131071 : COEFF_MIN;
         2: return CW'($urandom);
         3: return $urandom_range(0, 1) ? 18'sd0 : 18'sd65535;
         default: return 18'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   // random item: mostly an axis permutation with random signs and jitter, a quarter fully random coefficients
   function automatic matrix_item rand_item();
      matrix_item it;
      int perm [3];
      it.conv = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 9; i++) it.m[i] = rand_coeff();
      end else begin
         perm[0] = $urandom_range(0, 2);
         perm[1] = (perm[0] + 1 + $urandom_range(0, 1)) % 3;
         perm[2] = 3 - perm[0] - perm[1];
         for (int i = 0; i < 9; i++) it.m[i] = 18'(int'($urandom_range(0, 60000)) - 30000);
         for (int rw = 0; rw < 3; rw++)
            if ($urandom_range(0, 1)) it.m[rw * 3 + perm[rw]] = $urandom_range(0, 1)
               ? 18'(int'($urandom_range(40000, 70000))) : -18'(int'($urandom_range(40000, 70000)));
      end
      return it;
   endfunction

   // wait until every expected result has arrived, then let the pipeline drain
   task automatic drain();
      wait (pending_q.size() == 0 && !req_valid);
      wait (angles_q.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_unit(bit deg);
      @(posedge clock);
      csr_valid <= 1;
      csr_degrees <= deg;
      do @(posedge clock); while (!csr_ready);
      degrees_mode = deg;
      csr_valid <= 0;
   endtask

   // stimulus
   initial begin
      matrix_item it;
      repeat (5) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_unit(ph % 2);
         if (ph == 0) begin
            // identity, locks of both signs, extremes, invalid codes
            for (int c = 0; c < 16; c++) begin
               for (int i = 0; i < 9; i++) it.m[i] = (i % 4 == 0) ? 18'sd65536 : 18'sd0;
               it.conv = 4'(c);
               if (c % 3 == 1) for (int i = 0; i < 9; i++) it.m[i] = -it.m[i];
               pending_q.push_back(it);
            end
            for (int k = 0; k < 4; k++) begin
               it.conv = 4'(k * 3);
               for (int i = 0; i < 9; i++)
                  it.m[i] = (k % 2) ? COEFF_MIN : 18'sd131071;
               pending_q.push_back(it);
            end
            it.conv = CONV_ZYX;
            for (int i = 0; i < 9; i++) it.m[i] = '0;
            pending_q.push_back(it);
         end
         for (int n = 0; n < 100; n++) pending_q.push_back(rand_item());
         drain();
      end
      stimulus_done = 1;
   end

   // driver: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else if (pending_q.size() != 0 && !csr_valid) begin
            matrix_item it;
            it = pending_q.pop_front();
            req_valid <= 1;
            req_convention <= it.conv;
            for (int i = 0; i < 9; i++) cf[i] <= it.m[i];
            angles_q.push_back(euler_angles(it));
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall pattern and result checks
   always @(posedge clock) begin
      angle_set w;
      stall_phase <= stall_phase + 1;
      rsp_stall <= ((stall_phase / 200) % 3 == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angles_q.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            w = angles_q.pop_front();
            if (rsp_first_angle !== w.a1) report_mismatch("first_angle", rsp_first_angle, w.a1);
            if (rsp_second_angle !== w.a2) report_mismatch("second_angle", rsp_second_angle, w.a2);
            if (rsp_third_angle !== w.a3) report_mismatch("third_angle", rsp_third_angle, w.a3);
            if (rsp_bad_convention !== w.bad)
               report_mismatch("bad_convention", rsp_bad_convention, w.bad);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !stimulus_done) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      if (errors == 0 && angles_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
